FILE: hw/rtl/xld_pkg.sv
// Package for the XOR-linked style deque: operation and status codes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
package xld_pkg;

  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;
  localparam int unsigned WordW            = 32;
  localparam int unsigned OccW             = 5;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    push;
    logic    pop;
    logic    scan_start;
    logic    scan_next;
    logic    rev;
    logic    load;
    status_e load_status;
    logic    load_data;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic last;
    logic res_free;
  } stat_t;

endpackage

FILE: hw/rtl/xld_ctrl.sv
// Controller state machine of the deque: sequences each operation.
// Depends on xld_pkg; drives commands into xld_datapath.
module xld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  xld_pkg::stat_t stat_i,
  output xld_pkg::cmd_t  cmd_o
);

  xld_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xld_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      xld_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = xld_pkg::S_EXEC;
        end
      end
      xld_pkg::S_EXEC: begin
        if (stat_i.res_free) begin
          case (stat_i.op)
            xld_pkg::OP_POP: begin
              state_d = stat_i.empty ? xld_pkg::S_IDLE : xld_pkg::S_POPRD;
            end
            xld_pkg::OP_SEARCH: begin
              state_d = stat_i.empty ? xld_pkg::S_IDLE : xld_pkg::S_SCAN;
            end
            default: begin
              state_d = xld_pkg::S_IDLE;
            end
          endcase
        end
      end
      xld_pkg::S_POPRD: begin
        if (stat_i.res_free) begin
          state_d = xld_pkg::S_IDLE;
        end
      end
      xld_pkg::S_SCAN: begin
        if (stat_i.res_free && (stat_i.match || stat_i.last)) begin
          state_d = xld_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = xld_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.load_status = xld_pkg::ST_OK;
    in_stall_o = 1'b1;
    case (state_q)
      xld_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      xld_pkg::S_EXEC: begin
        if (stat_i.res_free) begin
          case (stat_i.op)
            xld_pkg::OP_PUSH: begin
              cmd_o.load = 1'b1;
              if (stat_i.full) begin
                cmd_o.load_status = xld_pkg::ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            xld_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.load        = 1'b1;
                cmd_o.load_status = xld_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            xld_pkg::OP_REVERSE: begin
              cmd_o.rev  = 1'b1;
              cmd_o.load = 1'b1;
            end
            xld_pkg::OP_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.load        = 1'b1;
                cmd_o.load_status = xld_pkg::ST_NOTFOUND;
              end else begin
                cmd_o.scan_start = 1'b1;
              end
            end
            default: begin
              cmd_o.load = 1'b0;
            end
          endcase
        end
      end
      xld_pkg::S_POPRD: begin
        if (stat_i.res_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_data = 1'b1;
        end
      end
      xld_pkg::S_SCAN: begin
        if (stat_i.res_free) begin
          if (stat_i.match) begin
            cmd_o.load      = 1'b1;
            cmd_o.load_data = 1'b1;
          end else if (stat_i.last) begin
            cmd_o.load        = 1'b1;
            cmd_o.load_status = xld_pkg::ST_NOTFOUND;
          end else begin
            cmd_o.scan_next = 1'b1;
          end
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Work is only started or finished while the result register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load || cmd_o.push || cmd_o.rev) |-> stat_i.res_free)
    else $error("result loaded while result register busy");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xld_pkg::S_SCAN) |-> !stat_i.empty)
    else $error("scan running on an empty deque");

  a_pop_goes_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == xld_pkg::S_POPRD))
    else $error("pop did not move to read wait");

endmodule

FILE: hw/rtl/xld_datapath.sv
// Datapath of the deque: word memory, front pointer, count, reverse flag,
// scan index, key compare and the result register. Depends on xld_pkg.
module xld_datapath #(
  parameter int unsigned DEPTH      = xld_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = xld_pkg::DefaultDataWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       func_i,
  input  logic                             at_tail_i,
  input  logic [xld_pkg::WordW-1:0]        value_i,
  input  logic [xld_pkg::WordW-1:0]        search_key_i,
  input  xld_pkg::cmd_t                    cmd_i,
  output xld_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [xld_pkg::WordW-1:0]        result_value_o,
  output logic [xld_pkg::OccW-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DepthW   = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rev_q;
  logic [AW-1:0]         idx_q;
  xld_pkg::op_e          op_q;
  logic                  back_q;
  logic [DATA_WIDTH-1:0] val_q, key_q, rdata_q;
  logic                  out_valid_q;
  xld_pkg::status_e      status_q;
  logic [xld_pkg::WordW-1:0] result_q;
  logic [xld_pkg::OccW-1:0]  occ_q;

  logic [63:0]           val_ext, key_ext, rd_ext;
  logic [15:0]           occ_ext;
  logic [AW:0]           count_w, scan_off, next_idx_w;
  logic [AW-1:0]         front_dec, front_inc, wr_addr, rd_addr;
  logic                  rd_en;

  // Physical slot of a logical offset from the front entry.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] front, input logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, front} + off;
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AW-1:0];
  endfunction

  assign val_ext = {32'b0, value_i};
  assign key_ext = {32'b0, search_key_i};
  assign count_w = (AW + 1)'(count_q);

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = slot(front_q, (AW + 1)'(1));

  // A scan in reversed order walks from the physical back toward the front.
  always_comb begin
    next_idx_w = cmd_i.scan_start ? '0 : {1'b0, idx_q} + (AW + 1)'(1);
    scan_off   = rev_q ? (count_w - (AW + 1)'(1) - next_idx_w) : next_idx_w;
  end

  always_comb begin
    wr_addr = back_q ? slot(front_q, count_w) : front_dec;
    rd_en   = cmd_i.pop || cmd_i.scan_start || cmd_i.scan_next;
    if (cmd_i.pop) begin
      rd_addr = back_q ? slot(front_q, count_w - (AW + 1)'(1)) : front_q;
    end else begin
      rd_addr = slot(front_q, scan_off);
    end
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      if (!back_q) begin
        front_d = front_dec;
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      if (!back_q) begin
        front_d = front_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.rev) begin
        rev_q <= !rev_q;
      end
    end
  end

  // Captured item and scan position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= xld_pkg::op_e'(func_i);
      back_q <= at_tail_i ^ rev_q;
      val_q  <= val_ext[DATA_WIDTH-1:0];
      key_q  <= key_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.scan_start || cmd_i.scan_next) begin
      idx_q <= next_idx_w[AW-1:0];
    end
  end

  assign rd_ext  = 64'(rdata_q);
  assign occ_ext = 16'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= cmd_i.load_status;
      result_q <= cmd_i.load_data ? rd_ext[xld_pkg::WordW-1:0] : '0;
      occ_q    <= occ_ext[xld_pkg::OccW-1:0];
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == DepthC);
  assign stat_o.match    = (rdata_q == key_q);
  assign stat_o.last     = ((AW + 1)'(idx_q) == count_w - (AW + 1)'(1));
  assign stat_o.res_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;
  assign occupancy_o    = occ_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != DepthC))
    else $error("push into a full deque");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from an empty deque");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the count by one");

endmodule

FILE: hw/rtl/xor_linked_deque.sv
// Top level of the bounded deque with push, pop, reverse and search.
// Depends on xld_pkg, xld_ctrl and xld_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid_i / in_stall_o | func_i, at_tail_i, value_i, search_key_i
//  output  | out_valid_o / out_stall_i | status_o, result_value_o, occupancy_o
//
// Push, reverse, pop on empty and search on empty: capture, then execute.
// Pop adds a read step; a search of a nonempty deque adds a compare per entry.
// Single read port: one entry is read per cycle unless a waiting result stalls.
// Reset clears count, front pointer and reverse flag; the memory is not cleared.
// The result register frees the input side: a new item is taken while a result waits.
// While a result waits on a stalled output, the next item holds in its current step.
module xor_linked_deque #(
  parameter int unsigned DEPTH      = xld_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = xld_pkg::DefaultDataWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic                      at_tail_i,
  input  logic [xld_pkg::WordW-1:0] value_i,
  input  logic [xld_pkg::WordW-1:0] search_key_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [xld_pkg::WordW-1:0] result_value_o,
  output logic [xld_pkg::OccW-1:0]  occupancy_o
);

  xld_pkg::cmd_t  cmd;
  xld_pkg::stat_t stat;

  xld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  xld_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (func_i),
    .at_tail_i      (at_tail_i),
    .value_i        (value_i),
    .search_key_i   (search_key_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

FILE: tb/xor_linked_deque_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded deque: directed table, then random items.
// Depends on xld_pkg and the xor_linked_deque RTL.
module xor_linked_deque_tb;

  localparam int unsigned Depth       = xld_pkg::DefaultDepth;
  localparam int unsigned IdxW        = $clog2(Depth);
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = Depth + 8;

  typedef struct packed {
    xld_pkg::status_e          status;
    logic [xld_pkg::WordW-1:0] value;
    logic [xld_pkg::OccW-1:0]  occ;
  } deque_result_t;

  typedef struct packed {
    xld_pkg::op_e              op;
    logic                      at_tail;
    logic [xld_pkg::WordW-1:0] word;
    logic [xld_pkg::WordW-1:0] key;
    int unsigned               reps;
    bit                        rand_data;
    bit                        fixed;
    deque_result_t             res;
  } dir_step_t;

  // Rows marked fixed carry their result; the rest are checked against the predictor.
  localparam dir_step_t DirectedSteps [25] = '{
    '{xld_pkg::OP_POP,     1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_EMPTY,    32'h0,        5'd0}},
    '{xld_pkg::OP_POP,     1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_EMPTY,    32'h0,        5'd0}},
    '{xld_pkg::OP_SEARCH,  1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_NOTFOUND, 32'h0,        5'd0}},
    '{xld_pkg::OP_REVERSE, 1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_REVERSE, 1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_PUSH,    1'b0, 32'hFFFFFFFF, 32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd1}},
    '{xld_pkg::OP_POP,     1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'hFFFFFFFF, 5'd0}},
    '{xld_pkg::OP_PUSH,    1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd1}},
    '{xld_pkg::OP_POP,     1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_PUSH,    1'b1, 32'h1,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd1}},
    '{xld_pkg::OP_PUSH,    1'b1, 32'h0,        32'h0,        13, 1'b1, 1'b0,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_PUSH,    1'b0, 32'hFFFFFFFF, 32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd15}},
    '{xld_pkg::OP_PUSH,    1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd16}},
    '{xld_pkg::OP_PUSH,    1'b0, 32'h12345678, 32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_FULL,     32'h0,        5'd16}},
    '{xld_pkg::OP_PUSH,    1'b1, 32'hFFFFFFFF, 32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_FULL,     32'h0,        5'd16}},
    '{xld_pkg::OP_SEARCH,  1'b0, 32'h0,        32'hFFFFFFFF, 1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'hFFFFFFFF, 5'd16}},
    '{xld_pkg::OP_SEARCH,  1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd16}},
    '{xld_pkg::OP_SEARCH,  1'b0, 32'h0,        32'h0,        1,  1'b1, 1'b0,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_REVERSE, 1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd16}},
    '{xld_pkg::OP_SEARCH,  1'b0, 32'h0,        32'h1,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h1,        5'd16}},
    '{xld_pkg::OP_POP,     1'b0, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'h0,        5'd15}},
    '{xld_pkg::OP_POP,     1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b1,
      '{xld_pkg::ST_OK,       32'hFFFFFFFF, 5'd14}},
    '{xld_pkg::OP_SEARCH,  1'b1, 32'h0,        32'h0,        1,  1'b1, 1'b0,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_POP,     1'b0, 32'h0,        32'h0,        2,  1'b0, 1'b0,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}},
    '{xld_pkg::OP_POP,     1'b1, 32'h0,        32'h0,        1,  1'b0, 1'b0,
      '{xld_pkg::ST_OK,       32'h0,        5'd0}}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                func_i;
  logic                      at_tail_i;
  logic [xld_pkg::WordW-1:0] value_i;
  logic [xld_pkg::WordW-1:0] search_key_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [1:0]                status_o;
  logic [xld_pkg::WordW-1:0] result_value_o;
  logic [xld_pkg::OccW-1:0]  occupancy_o;

  xor_linked_deque u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .at_tail_i     (at_tail_i),
    .value_i       (value_i),
    .search_key_i  (search_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_value_o(result_value_o),
    .occupancy_o   (occupancy_o)
  );

  // Predictor state: circular word store, front slot, fill level and end swap.
  logic [xld_pkg::WordW-1:0] model_store [Depth];
  logic [IdxW-1:0]           model_front;
  int unsigned               model_count;
  bit                        model_rev;

  deque_result_t pending_results[$];
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   items_sent;
  int unsigned   full_pushes, empty_pops, missed_searches, reversals;
  bit            steady_mode;
  bit            hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic deque_result_t deque_apply(xld_pkg::op_e op, logic at_tail,
                                                logic [xld_pkg::WordW-1:0] word,
                                                logic [xld_pkg::WordW-1:0] key);
    deque_result_t   r;
    logic            back;
    logic [IdxW-1:0] slot;
    int unsigned     off;
    r.status = xld_pkg::ST_OK;
    r.value  = '0;
    back     = at_tail ^ model_rev;
    case (op)
      xld_pkg::OP_PUSH: begin
        if (model_count >= Depth) begin
          r.status = xld_pkg::ST_FULL;
        end else begin
          if (back) begin
            slot = model_front + IdxW'(model_count);
            model_store[slot] = word;
          end else begin
            model_front = model_front - 1'b1;
            model_store[model_front] = word;
          end
          model_count++;
        end
      end
      xld_pkg::OP_POP: begin
        if (model_count == 0) begin
          r.status = xld_pkg::ST_EMPTY;
        end else begin
          if (back) begin
            slot = model_front + IdxW'(model_count - 1);
            r.value = model_store[slot];
          end else begin
            r.value = model_store[model_front];
            model_front = model_front + 1'b1;
          end
          model_count--;
        end
      end
      xld_pkg::OP_REVERSE: model_rev = !model_rev;
      default: begin
        r.status = xld_pkg::ST_NOTFOUND;
        for (int unsigned i = 0; i < model_count; i++) begin
          off  = model_rev ? model_count - 1 - i : i;
          slot = model_front + IdxW'(off);
          if (model_store[slot] == key) begin
            r.status = xld_pkg::ST_OK;
            r.value  = key;
            break;
          end
        end
      end
    endcase
    r.occ = xld_pkg::OccW'(model_count);
    return r;
  endfunction

  function automatic logic [xld_pkg::WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return xld_pkg::WordW'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // Most searches aim at a stored word so that hits land at every depth.
  function automatic logic [xld_pkg::WordW-1:0] pick_key();
    logic [IdxW-1:0] slot;
    if (model_count != 0 && $urandom_range(9) < 6) begin
      slot = model_front + IdxW'($urandom_range(model_count - 1));
      return model_store[slot];
    end
    return pick_word();
  endfunction

  task automatic report_mismatch(string field, logic [xld_pkg::WordW-1:0] got,
                                 logic [xld_pkg::WordW-1:0] want);
    $display("Mismatch in result %0d, %s: got %h, expected %h",
             results_seen, field, got, want);
    errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_item(xld_pkg::op_e op, logic at_tail,
                            logic [xld_pkg::WordW-1:0] word,
                            logic [xld_pkg::WordW-1:0] key, bit fixed,
                            deque_result_t fixed_res);
    deque_result_t predicted;
    while (!steady_mode && $urandom_range(99) < 30) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    func_i       = op;
    at_tail_i    = at_tail;
    value_i      = word;
    search_key_i = key;
    do @(posedge clk_i); while (in_stall_o);
    predicted = deque_apply(op, at_tail, word, key);
    pending_results.push_back(fixed ? fixed_res : predicted);
    items_sent++;
    case (predicted.status)
      xld_pkg::ST_FULL:     full_pushes++;
      xld_pkg::ST_EMPTY:    empty_pops++;
      xld_pkg::ST_NOTFOUND: missed_searches++;
      default:              if (op == xld_pkg::OP_REVERSE) reversals++;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_value_o, '0);
      end else begin
        deque_result_t want;
        want = pending_results.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (result_value_o != want.value) report_mismatch("value", result_value_o, want.value);
        if (occupancy_o != want.occ) report_mismatch("occupancy", occupancy_o, want.occ);
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        for (int unsigned c = 0; c < HoldCycles; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i = !steady_mode && ($urandom_range(99) < 30);
    end
  end

  initial begin
    xld_pkg::op_e              op;
    logic [xld_pkg::WordW-1:0] word, key;
    int unsigned               push_bias, pick;
    in_valid_i   = 1'b0;
    func_i       = xld_pkg::OP_PUSH;
    at_tail_i    = 1'b0;
    value_i      = '0;
    search_key_i = '0;
    rst_ni       = 1'b0;
    steady_mode  = 1'b0;
    hold_req     = 1'b0;
    model_front  = '0;
    model_count  = 0;
    model_rev    = 1'b0;
    push_bias    = 50;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedSteps[i]) begin
      for (int unsigned r = 0; r < DirectedSteps[i].reps; r++) begin
        word = DirectedSteps[i].rand_data ? $urandom : DirectedSteps[i].word;
        key  = DirectedSteps[i].rand_data ? pick_key() : DirectedSteps[i].key;
        offer_item(DirectedSteps[i].op, DirectedSteps[i].at_tail, word, key,
                   DirectedSteps[i].fixed, DirectedSteps[i].res);
      end
    end
    in_valid_i = 1'b0;
    wait_drained();

    for (int unsigned n = 0; n < RandomItems; n++) begin
      // Push bias changes in blocks so the queue swings between empty and full.
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      if (n == 300) hold_req = 1'b1;
      if (n == 1000) begin
        in_valid_i = 1'b0;
        wait_drained();
      end
      steady_mode = (n >= 1200 && n < 1500);
      pick = $urandom_range(99);
      if (pick < 8) op = xld_pkg::OP_REVERSE;
      else if (pick < 23) op = xld_pkg::OP_SEARCH;
      else if ($urandom_range(99) < push_bias) op = xld_pkg::OP_PUSH;
      else op = xld_pkg::OP_POP;
      word = pick_word();
      key  = pick_key();
      offer_item(op, 1'($urandom_range(1)), word, key, 1'b0, '0);
    end
    steady_mode = 1'b0;
    in_valid_i  = 1'b0;
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);

    $display("Ran %0d items: %0d reversals, %0d pushes on full, %0d pops on empty,",
             items_sent, reversals, full_pushes, empty_pops);
    $display("%0d searches without a match, %0d results checked, %0d mismatches",
             missed_searches, results_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
